>>> hdl/prz_pkg.sv
package prz_pkg;

	// Offset arithmetic: 33-bit exact offset, guard fraction bits, CORDIC word width.
	localparam int GUARD_BITS = 8;
	localparam int DW         = 44;
	localparam int ZW         = 32;
	localparam int TAB_LEN    = 30;

	localparam longint EPS_DENOM = 100000;

	// Inverse CORDIC gain 0.6072529350 in Q0.32, split into 16-bit halves.
	localparam logic [31:0] INV_GAIN = 32'd2608131496;
	localparam logic [15:0] GAIN_HI  = INV_GAIN[31:16];
	localparam logic [15:0] GAIN_LO  = INV_GAIN[15:0];

	// Quarter-turn codes of the coarse rotation.
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	// Values that ride alongside the rotation: the base that the offset is
	// added to, z, and whether a rotated offset is added at all.
	typedef struct packed {
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [31:0]        pz;
		logic               rot;
	} side_t;

	// atan(2^-i) in units of 2^-32 turn, rounded.
	function automatic logic signed [ZW-1:0] prz_atan(input logic [4:0] idx);
		logic signed [ZW-1:0] a;
		case (idx)
			5'd0:    a = 32'sd536870912;
			5'd1:    a = 32'sd316933406;
			5'd2:    a = 32'sd167458907;
			5'd3:    a = 32'sd85004756;
			5'd4:    a = 32'sd42667331;
			5'd5:    a = 32'sd21354465;
			5'd6:    a = 32'sd10679838;
			5'd7:    a = 32'sd5340245;
			5'd8:    a = 32'sd2670163;
			5'd9:    a = 32'sd1335087;
			5'd10:   a = 32'sd667544;
			5'd11:   a = 32'sd333772;
			5'd12:   a = 32'sd166886;
			5'd13:   a = 32'sd83443;
			5'd14:   a = 32'sd41722;
			5'd15:   a = 32'sd20861;
			5'd16:   a = 32'sd10430;
			5'd17:   a = 32'sd5215;
			5'd18:   a = 32'sd2608;
			5'd19:   a = 32'sd1304;
			5'd20:   a = 32'sd652;
			5'd21:   a = 32'sd326;
			5'd22:   a = 32'sd163;
			5'd23:   a = 32'sd81;
			5'd24:   a = 32'sd41;
			5'd25:   a = 32'sd20;
			5'd26:   a = 32'sd10;
			5'd27:   a = 32'sd5;
			5'd28:   a = 32'sd3;
			5'd29:   a = 32'sd1;
			default: a = 32'sd0;
		endcase
		return a;
	endfunction

endpackage

>>> hdl/point_rotate_about_z.sv
// Rotates a 3D point about the z axis through a center point.
// Input stream (s_*): one word per point, taken when s_tvalid and s_tready are high.
// s_tdata carries point x/y/z, center x/y (signed Q16.16) and the turn angle
// (16-bit binary angle, counterclockwise); s_tuser is the about-z flag. With the
// flag clear the point comes back unchanged.
// Output stream (m_*): one word per input word, in order. m_tdata carries the
// rotated x/y (saturated) and z; m_tuser is set when x or y saturated.
// The pipeline has two setup stages, one stage per CORDIC micro-rotation, and
// four stages for gain compensation, rounding and the final add with saturation.
// It accepts one word every cycle while s_tready is high.
// Reset empties every stage; no word is in flight afterwards.
// When m_tready is low, earlier stages keep advancing into empty slots, so
// s_tready stays high until every stage holds a word. Nothing is lost or
// repeated across a stall.
module point_rotate_about_z import prz_pkg::*; #(
	parameter int CORDIC_STAGES   = 16,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, point_z, center_x, center_y, turn_angle
	input  logic [175:0] s_tdata,
	// about_z
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [95:0]  m_tdata,
	// overflow
	output logic         m_tuser
);

	logic  pre_valid, pre_ready, cor_valid, cor_ready;
	vec_t  pre_vec, cor_vec;
	side_t pre_side, cor_side;
	logic signed [31:0] res_x, res_y;
	logic [31:0] res_z;

	prz_prep #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.point_x   (s_tdata[31:0]),
		.point_y   (s_tdata[63:32]),
		.point_z   (s_tdata[95:64]),
		.center_x  (s_tdata[127:96]),
		.center_y  (s_tdata[159:128]),
		.turn_angle(s_tdata[175:160]),
		.about_z   (s_tuser),
		.out_valid (pre_valid),
		.out_ready (pre_ready),
		.out_vec   (pre_vec),
		.out_side  (pre_side)
	);

	prz_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pre_valid),
		.in_ready (pre_ready),
		.in_vec   (pre_vec),
		.in_side  (pre_side),
		.out_valid(cor_valid),
		.out_ready(cor_ready),
		.out_vec  (cor_vec),
		.out_side (cor_side)
	);

	prz_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cor_valid),
		.in_ready (cor_ready),
		.in_vec   (cor_vec),
		.in_side  (cor_side),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_x    (res_x),
		.out_y    (res_y),
		.out_z    (res_z),
		.overflow (m_tuser)
	);

	assign m_tdata = {res_z, res_y, res_x};

`ifndef ASSERT_OFF
	// Input backpressure can only come from a stalled, full output.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("s_tready low without a stalled output word");

	// A saturation flag must come with a clamped coordinate.
	a_ovf_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
			 m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000))
		else $error("overflow flagged on an unsaturated word");
`endif

endmodule

>>> hdl/prz_prep.sv
module prz_prep import prz_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic [15:0]        turn_angle,
	input  logic               about_z,
	output logic               out_valid,
	input  logic               out_ready,
	output vec_t               out_vec,
	output side_t              out_side
);

	// Largest offset magnitude m with m * 100000 < 2^COORD_FRAC_BITS.
	localparam longint EPS_MAX = ((longint'(1) << COORD_FRAC_BITS) - 1) / EPS_DENOM;
	localparam logic signed [32:0] EPS_POS = 33'(EPS_MAX);
	localparam logic signed [32:0] EPS_NEG = -EPS_POS;

	logic               v_s1, v_s2;
	logic               rdy_s1, rdy_s2;
	logic signed [32:0] dx_s1, dy_s1;
	logic [1:0]         q_s1;
	logic [15:0]        res_s1;
	side_t              sd_s1, sd_s2;
	vec_t               vec_s2;

	logic [15:0]        ang_sum;
	logic [1:0]         q_d;
	logic [15:0]        res_d;
	side_t              sd_d;
	logic signed [DW-1:0] gx, gy;
	vec_t               vec_d;
	logic               nzx, nzy;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Nearest quarter turn; the residue is the signed remainder in 16-bit units.
	always_comb begin
		ang_sum  = turn_angle + 16'd8192;
		q_d      = ang_sum[15:14];
		res_d    = turn_angle - {q_d, 14'b0};
		sd_d.bx  = about_z ? center_x : point_x;
		sd_d.by  = about_z ? center_y : point_y;
		sd_d.pz  = point_z;
		sd_d.rot = about_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			dx_s1  <= {point_x[31], point_x} - {center_x[31], center_x};
			dy_s1  <= {point_y[31], point_y} - {center_y[31], center_y};
			q_s1   <= q_d;
			res_s1 <= res_d;
			sd_s1  <= sd_d;
		end
	end

	always_comb begin
		gx = {{(DW-33-GUARD_BITS){dx_s1[32]}}, dx_s1, {GUARD_BITS{1'b0}}};
		gy = {{(DW-33-GUARD_BITS){dy_s1[32]}}, dy_s1, {GUARD_BITS{1'b0}}};
		unique case (q_s1)
			QUAD_0: begin
				vec_d.x = gx;
				vec_d.y = gy;
			end
			QUAD_1: begin
				vec_d.x = -gy;
				vec_d.y = gx;
			end
			QUAD_2: begin
				vec_d.x = -gx;
				vec_d.y = -gy;
			end
			default: begin
				vec_d.x = gy;
				vec_d.y = -gx;
			end
		endcase
		vec_d.z = {res_s1, 16'b0};
		nzx = (dx_s1 >= EPS_NEG) && (dx_s1 <= EPS_POS);
		nzy = (dy_s1 >= EPS_NEG) && (dy_s1 <= EPS_POS);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			vec_s2 <= vec_d;
			// A vanishing offset leaves the center itself as the answer.
			sd_s2  <= '{bx: sd_s1.bx, by: sd_s1.by, pz: sd_s1.pz,
				rot: sd_s1.rot && !(nzx && nzy)};
		end
	end

	assign out_valid = v_s2;
	assign out_vec   = vec_s2;
	assign out_side  = sd_s2;

endmodule

>>> hdl/prz_cordic.sv
module prz_cordic import prz_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  vec_t  in_vec,
	input  side_t in_side,
	output logic  out_valid,
	input  logic  out_ready,
	output vec_t  out_vec,
	output side_t out_side
);

	localparam int N = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

	logic [N-1:0] v_s;
	logic [N:0]   rdy;
	vec_t         vec_s [N];
	side_t        sd_s  [N];
	logic [N-1:0] vin_v;
	vec_t         vin   [N];
	side_t        sin   [N];

	assign rdy[N]   = out_ready;
	assign in_ready = rdy[0];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [DW-1:0] cx, cy;
		logic signed [ZW-1:0] cz;
		vec_t                 nxt;

		if (i == 0) begin : g_first
			assign vin_v[i] = in_valid;
			assign vin[i]   = in_vec;
			assign sin[i]   = in_side;
		end else begin : g_next
			assign vin_v[i] = v_s[i-1];
			assign vin[i]   = vec_s[i-1];
			assign sin[i]   = sd_s[i-1];
		end

		assign rdy[i] = !v_s[i] || rdy[i+1];

		// One micro-rotation: the sign of the residual angle picks the direction.
		always_comb begin
			cx = vin[i].x;
			cy = vin[i].y;
			cz = vin[i].z;
			if (!cz[ZW-1]) begin
				nxt.x = cx - (cy >>> i);
				nxt.y = cy + (cx >>> i);
				nxt.z = cz - prz_atan(5'(i));
			end else begin
				nxt.x = cx + (cy >>> i);
				nxt.y = cy - (cx >>> i);
				nxt.z = cz + prz_atan(5'(i));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_s[i] <= vin_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && vin_v[i]) begin
				vec_s[i] <= nxt;
				sd_s[i]  <= sin[i];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_vec   = vec_s[N-1];
	assign out_side  = sd_s[N-1];

endmodule

>>> hdl/prz_post.sv
module prz_post import prz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vec_t               in_vec,
	input  side_t              in_side,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic [31:0]        out_z,
	output logic               overflow
);

	localparam int MW = DW - 1;
	localparam int PW = MW + 16;
	localparam int RW = PW + 1 - 16 - GUARD_BITS;
	localparam int SW = RW + 2;
	localparam logic [PW:0] RND = (PW+1)'(1) << (15 + GUARD_BITS);

	logic           v_s1, v_s2, v_s3, v_s4;
	logic           rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	side_t          sd_s1, sd_s2, sd_s3;
	logic [MW-1:0]  mx_s1, my_s1;
	logic           nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3;
	logic [PW-1:0]  phx_s2, plx_s2, phy_s2, ply_s2;
	logic [RW-1:0]  rx_s3, ry_s3;
	logic signed [31:0] x_s4, y_s4;
	logic [31:0]    z_s4;
	logic           ovf_s4;

	logic signed [DW-1:0] ax, ay;
	logic [DW-1:0]  magx, magy;
	logic [PW:0]    px, py;
	logic signed [SW-1:0] bx, by, sx, sy;
	logic           okx, oky;
	logic signed [31:0] ox, oy;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Gain compensation works on magnitudes; the sign is put back at the final add.
	always_comb begin
		ax   = in_vec.x;
		ay   = in_vec.y;
		magx = ax[DW-1] ? DW'(-ax) : DW'(ax);
		magy = ay[DW-1] ? DW'(-ay) : DW'(ay);
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mx_s1 <= magx[MW-1:0];
			my_s1 <= magy[MW-1:0];
			nx_s1 <= ax[DW-1];
			ny_s1 <= ay[DW-1];
			sd_s1 <= in_side;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			phx_s2 <= PW'(mx_s1) * PW'(GAIN_HI);
			plx_s2 <= PW'(mx_s1) * PW'(GAIN_LO);
			phy_s2 <= PW'(my_s1) * PW'(GAIN_HI);
			ply_s2 <= PW'(my_s1) * PW'(GAIN_LO);
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			sd_s2  <= sd_s1;
		end
	end

	// The low partial product drops 16 bits; then round half up and drop the guard bits.
	always_comb begin
		px = (PW+1)'(phx_s2) + (PW+1)'(plx_s2 >> 16) + RND;
		py = (PW+1)'(phy_s2) + (PW+1)'(ply_s2 >> 16) + RND;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			rx_s3 <= px[PW:16+GUARD_BITS];
			ry_s3 <= py[PW:16+GUARD_BITS];
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			sd_s3 <= sd_s2;
		end
	end

	always_comb begin
		bx  = SW'(sd_s3.bx);
		by  = SW'(sd_s3.by);
		sx  = nx_s3 ? bx - signed'(SW'(rx_s3)) : bx + signed'(SW'(rx_s3));
		sy  = ny_s3 ? by - signed'(SW'(ry_s3)) : by + signed'(SW'(ry_s3));
		okx = (&sx[SW-1:31]) || !(|sx[SW-1:31]);
		oky = (&sy[SW-1:31]) || !(|sy[SW-1:31]);
		ox  = okx ? sx[31:0] : (sx[SW-1] ? 32'sh80000000 : 32'sh7fffffff);
		oy  = oky ? sy[31:0] : (sy[SW-1] ? 32'sh80000000 : 32'sh7fffffff);
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			x_s4   <= sd_s3.rot ? ox : sd_s3.bx;
			y_s4   <= sd_s3.rot ? oy : sd_s3.by;
			z_s4   <= sd_s3.pz;
			ovf_s4 <= sd_s3.rot && !(okx && oky);
		end
	end

	assign out_valid = v_s4;
	assign out_x     = x_s4;
	assign out_y     = y_s4;
	assign out_z     = z_s4;
	assign overflow  = ovf_s4;

endmodule
